// ===== hw/rtl/ahfp_pkg.sv =====
// shared types and constants of the ascii heading field parser
package ahfp_pkg;

   localparam int FRAME_LEN_DEFAULT = 25;
   localparam int FIELD_N           = 5;
   localparam int FILL_W            = 3;
   localparam int BYTE_W            = 8;
   localparam int HEAD_W            = 23;
   localparam int CODE_W            = 3;
   localparam int CALC_W            = 24;

   localparam logic [BYTE_W-1:0] CH_COMMA   = 8'd44;
   localparam logic [BYTE_W-1:0] CH_MINUS   = 8'd45;
   localparam logic [BYTE_W-1:0] CH_DOT     = 8'd46;
   localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'd48;

   localparam logic [1:0] COMMA_MAX = 2'd2;

   typedef enum logic [CODE_W-1:0] {
      FMT_NONE       = 3'd0,
      FMT_NEG_INT    = 3'd1,
      FMT_NEG_TENTHS = 3'd2,
      FMT_TENTHS     = 3'd3,
      FMT_HUNDREDTHS = 3'd4
   } format_type;

   typedef struct packed {
      logic                            valid;
      logic [FIELD_N-1:0][BYTE_W-1:0] bytes;
   } frame_type;

endpackage

// ===== hw/rtl/ahfp_req_if.sv =====
// request channel carrying one received byte
interface ahfp_req_if;
   logic                       valid;
   logic                       ready;
   logic [ahfp_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/ahfp_rsp_if.sv =====
// response channel carrying one decoded heading
interface ahfp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ahfp_pkg::HEAD_W-1:0] heading_hundredths;
   logic [ahfp_pkg::CODE_W-1:0]        format_code;

   modport source (output valid, output heading_hundredths, output format_code, input ready);
   modport sink (input valid, input heading_hundredths, input format_code, output ready);
endinterface

// ===== hw/rtl/ahfp_frame_tracker.sv =====
// frame position, comma count and field capture, hands the kept bytes on at frame end
module ahfp_frame_tracker #(
   parameter int FRAME_LEN = ahfp_pkg::FRAME_LEN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   ahfp_req_if.sink            req,
   output ahfp_pkg::frame_type frame,
   input  logic                frame_ready
);

   localparam int               POS_W    = $clog2(FRAME_LEN);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

   logic [POS_W-1:0]                                  pos_ff, pos_in;
   logic [1:0]                                        count_ff, count_in;
   logic [ahfp_pkg::FILL_W-1:0]                       fill_ff, fill_in;
   logic [ahfp_pkg::FIELD_N-1:0][ahfp_pkg::BYTE_W-1:0] field_ff, field_in;
   logic [ahfp_pkg::FIELD_N-1:0][ahfp_pkg::BYTE_W-1:0] fallback_ff, fallback_in;
   logic [ahfp_pkg::FIELD_N-1:0][ahfp_pkg::BYTE_W-1:0] field_upd;
   logic [1:0]                                        count_upd;
   logic                                              mid_valid_ff, mid_valid_in;
   logic [ahfp_pkg::FIELD_N-1:0][ahfp_pkg::BYTE_W-1:0] mid_bytes_ff, mid_bytes_in;
   logic                                              last_pos;
   logic                                              accept;

   assign last_pos  = (pos_ff == LAST_POS);
   assign req.ready = !(mid_valid_ff && last_pos);
   assign accept    = req.valid && req.ready;

   always_comb begin
      pos_in       = pos_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      field_in     = field_ff;
      fallback_in  = fallback_ff;
      field_upd    = field_ff;
      count_upd    = count_ff;
      mid_bytes_in = mid_bytes_ff;
      mid_valid_in = mid_valid_ff && !frame_ready;
      if (accept) begin
         for (int i = 0; i < ahfp_pkg::FIELD_N; i++) begin
            if (pos_ff == POS_W'(i + 1)) begin
               fallback_in[i] = req.rx_byte;
            end
         end
         if (count_ff == ahfp_pkg::COMMA_MAX && fill_ff < ahfp_pkg::FILL_W'(ahfp_pkg::FIELD_N)) begin
            for (int i = 0; i < ahfp_pkg::FIELD_N; i++) begin
               if (fill_ff == ahfp_pkg::FILL_W'(i)) begin
                  field_upd[i] = req.rx_byte;
               end
            end
            fill_in = fill_ff + 1'b1;
         end
         if (req.rx_byte == ahfp_pkg::CH_COMMA && count_ff != ahfp_pkg::COMMA_MAX) begin
            count_upd = count_ff + 1'b1;
         end
         if (last_pos) begin
            mid_bytes_in = (count_upd == ahfp_pkg::COMMA_MAX) ? field_upd : fallback_in;
            mid_valid_in = 1'b1;
            pos_in       = '0;
            count_in     = '0;
            fill_in      = '0;
            field_in     = '0;
         end else begin
            pos_in   = pos_ff + 1'b1;
            count_in = count_upd;
            field_in = field_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         field_ff     <= '0;
         mid_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         field_ff     <= field_in;
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fallback_ff  <= fallback_in;
      mid_bytes_ff <= mid_bytes_in;
   end

   assign frame.valid = mid_valid_ff;
   assign frame.bytes = mid_bytes_ff;

endmodule

// ===== hw/rtl/ahfp_decoder.sv =====
// heading format match and fixed point value, held in the response register
module ahfp_decoder (
   input  logic                clock,
   input  logic                reset,
   input  ahfp_pkg::frame_type frame,
   output logic                frame_ready,
   ahfp_rsp_if.source          rsp
);

   localparam int CW = ahfp_pkg::CALC_W;

   logic signed [CW-1:0]             d0, d1, d2, d3, d4;
   logic signed [CW-1:0]             value;
   ahfp_pkg::format_type             code;
   logic                             out_valid_ff, out_valid_in;
   logic signed [ahfp_pkg::HEAD_W-1:0] head_ff;
   ahfp_pkg::format_type             code_ff;
   logic                             load;

   assign d0 = $signed({{(CW - ahfp_pkg::BYTE_W){1'b0}}, frame.bytes[0]})
             - $signed(CW'(ahfp_pkg::DIGIT_BASE));
   assign d1 = $signed({{(CW - ahfp_pkg::BYTE_W){1'b0}}, frame.bytes[1]})
             - $signed(CW'(ahfp_pkg::DIGIT_BASE));
   assign d2 = $signed({{(CW - ahfp_pkg::BYTE_W){1'b0}}, frame.bytes[2]})
             - $signed(CW'(ahfp_pkg::DIGIT_BASE));
   assign d3 = $signed({{(CW - ahfp_pkg::BYTE_W){1'b0}}, frame.bytes[3]})
             - $signed(CW'(ahfp_pkg::DIGIT_BASE));
   assign d4 = $signed({{(CW - ahfp_pkg::BYTE_W){1'b0}}, frame.bytes[4]})
             - $signed(CW'(ahfp_pkg::DIGIT_BASE));

   // later formats override earlier ones
   always_comb begin
      value = '0;
      code  = ahfp_pkg::FMT_NONE;
      if (frame.bytes[0] == ahfp_pkg::CH_MINUS) begin
         if (frame.bytes[4] == ahfp_pkg::CH_DOT) begin
            value = -(d1 * 24'sd10000 + d2 * 24'sd1000 + d3 * 24'sd100);
            code  = ahfp_pkg::FMT_NEG_INT;
         end
         if (frame.bytes[3] == ahfp_pkg::CH_DOT) begin
            value = -(d1 * 24'sd1000 + d2 * 24'sd100 + d4 * 24'sd10);
            code  = ahfp_pkg::FMT_NEG_TENTHS;
         end
      end else if (frame.bytes[3] == ahfp_pkg::CH_DOT) begin
         value = d0 * 24'sd10000 + d1 * 24'sd1000 + d2 * 24'sd100 + d4 * 24'sd10;
         code  = ahfp_pkg::FMT_TENTHS;
      end
      if (frame.bytes[2] == ahfp_pkg::CH_DOT) begin
         value = d0 * 24'sd1000 + d1 * 24'sd100 + d3 * 24'sd10 + d4;
         code  = ahfp_pkg::FMT_HUNDREDTHS;
      end
   end

   assign frame_ready  = !out_valid_ff || rsp.ready;
   assign load         = frame.valid && frame_ready;
   assign out_valid_in = load || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         head_ff <= value[ahfp_pkg::HEAD_W-1:0];
         code_ff <= code;
      end
   end

   assign rsp.valid              = out_valid_ff;
   assign rsp.heading_hundredths = head_ff;
   assign rsp.format_code        = code_ff;

endmodule

// ===== hw/rtl/ascii_heading_field_parser_unit.sv =====
// top level of the ascii heading field parser
// a frame's bytes pass the middle register, then its result the response register
// one byte per cycle unless stalled; one result per frame of FRAME_LEN bytes
// the request side stalls only on a frame's last byte while the previous
// frame's bytes still sit in the middle register, held by a stalled response
// reset clears position, comma count, field capture and all valid flags
module ascii_heading_field_parser_unit #(
   parameter int FRAME_LEN = ahfp_pkg::FRAME_LEN_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ahfp_req_if.sink   req_bus,
   ahfp_rsp_if.source rsp_bus
);

   ahfp_pkg::frame_type frame;
   logic                frame_ready;

   ahfp_frame_tracker #(
      .FRAME_LEN(FRAME_LEN)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .frame      (frame),
      .frame_ready(frame_ready)
   );

   ahfp_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .frame      (frame),
      .frame_ready(frame_ready),
      .rsp        (rsp_bus)
   );

endmodule

// ===== hw/rtl/ahfp_checker.sv =====
// port level checks of the ascii heading field parser, bound to the top level
module ahfp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [ahfp_pkg::HEAD_W-1:0] heading_hundredths,
   input logic [ahfp_pkg::CODE_W-1:0]        format_code
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(heading_hundredths)
                                  && $stable(format_code))
      else $error("stalled response changed");

   // a fresh response follows an accepted frame end request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a frame end request");

   // no format means zero heading
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && format_code == ahfp_pkg::FMT_NONE |-> heading_hundredths == '0)
      else $error("nonzero heading without format");

   // code and value within range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> format_code <= ahfp_pkg::FMT_HUNDREDTHS
                    && heading_hundredths <= 23'sd2400000
                    && heading_hundredths >= -23'sd2400000)
      else $error("response out of range");

   // nothing offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ascii_heading_field_parser_unit ahfp_checker u_ahfp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .heading_hundredths(rsp_bus.heading_hundredths),
   .format_code       (rsp_bus.format_code)
);
